FILE: src/kmgd_pkg.sv
// Package with the sizes, request codes and sequencer states of the key matrix debouncer.
package kmgd_pkg;

  localparam int ROWS = 8;
  localparam int COLS = 18;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ONES_W = $clog2(COLS + 1);
  localparam int ACC_W = $clog2(ROWS * COLS + 1);

  localparam int REQ_W = 2;
  localparam int IDX_W = 3;
  localparam int BITS_W = 18;
  localparam int OROW_W = 18;
  localparam int KCNT_W = 8;
  localparam int DEB_W = 8;
  localparam int ELAPSED_W = 16;

  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd5;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam int KEY_MAX = 255;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE   = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_SCAN_END = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

FILE: src/key_matrix_global_debounce.sv
// Top level of the keyboard matrix scanner with one shared debounce timer.
//
// Input stream: s_axis_tuser carries the request kind (row sample, millisecond
// tick, end of scan pass); s_axis_tdata carries the row index and the sampled
// column bits. Every input transaction produces exactly one output transaction
// with the debounced bits of the named row, the pressed-key count and two flags.
// The debounce interval is written through cfg_we/cfg_wdata; the user must do so
// only while idle, as the block itself does not enforce it.
//
// After acceptance the item first updates the raw rows and the timer, then walks
// the rows one at a time through the single bit counter (copying raw to debounced
// rows on a commit), and last loads the output register.
// The output register parts the two sides: a new item is accepted while a
// finished result waits, but the walk stalls in its last state until the
// receiver has taken the previous result.
// Reset (rst, synchronous) clears both row stores, the pending flag and the
// timer, sets the debounce interval to 5 ms and empties the output register.
module key_matrix_global_debounce (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [kmgd_pkg::DEB_W-1:0]         cfg_wdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [2:0] row_index, [20:3] row_bits, [23:21] zero
  input  logic [kmgd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] req_type
  input  logic [kmgd_pkg::REQ_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [17:0] debounced_row, [25:18] key_count, [31:26] zero
  output logic [kmgd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [0] pending, [1] committed
  output logic [kmgd_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

  kmgd_pkg::state_t state, state_next;

  logic [kmgd_pkg::DEB_W-1:0]     debounce_ms;
  logic [kmgd_pkg::COLS-1:0]      raw_rows [kmgd_pkg::ROWS];
  logic [kmgd_pkg::COLS-1:0]      stable_rows [kmgd_pkg::ROWS];
  logic                           pending;
  logic [kmgd_pkg::ELAPSED_W-1:0] elapsed_ms;

  kmgd_pkg::req_t                 req;
  logic [kmgd_pkg::IDX_W-1:0]     row_idx;
  logic [kmgd_pkg::COLS-1:0]      bits;
  logic                           commit;
  logic [kmgd_pkg::ROW_W-1:0]     wk;
  logic [kmgd_pkg::ACC_W-1:0]     acc;
  logic [kmgd_pkg::COLS-1:0]      drow;

  logic                           in_fire;
  logic                           out_load;
  logic                           row_ok;
  logic [kmgd_pkg::ROW_W-1:0]     row_sel;
  logic [kmgd_pkg::ROW_W-1:0]     raw_addr;
  logic [kmgd_pkg::COLS-1:0]      raw_rd;
  logic [kmgd_pkg::COLS-1:0]      walk_val;
  logic [kmgd_pkg::ONES_W-1:0]    walk_ones;
  logic                           walk_last;
  logic                           commit_ok;
  logic [kmgd_pkg::KCNT_W-1:0]    key_count;

  assign row_ok    = 32'(row_idx) < 32'(kmgd_pkg::ROWS);
  assign row_sel   = kmgd_pkg::ROW_W'(row_idx);
  assign raw_addr  = (state == kmgd_pkg::ST_APPLY) ? row_sel : wk;
  assign raw_rd    = raw_rows[raw_addr];
  assign walk_val  = commit ? raw_rd : stable_rows[wk];
  assign walk_last = (wk == kmgd_pkg::ROW_W'(kmgd_pkg::ROWS - 1));
  assign commit_ok = pending && (elapsed_ms > kmgd_pkg::ELAPSED_W'(debounce_ms));
  assign key_count = (32'(acc) > 32'(kmgd_pkg::KEY_MAX)) ? kmgd_pkg::KCNT_W'(kmgd_pkg::KEY_MAX)
                                                         : kmgd_pkg::KCNT_W'(acc);

  kmgd_popcount u_popcount (
    .row  (walk_val),
    .ones (walk_ones)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      kmgd_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_next = kmgd_pkg::ST_APPLY;
      end
      kmgd_pkg::ST_APPLY: state_next = kmgd_pkg::ST_WALK;
      kmgd_pkg::ST_WALK: begin
        if (walk_last) state_next = kmgd_pkg::ST_DONE;
      end
      kmgd_pkg::ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = kmgd_pkg::ST_IDLE;
      end
      default: state_next = kmgd_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      kmgd_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      kmgd_pkg::ST_APPLY: ;
      kmgd_pkg::ST_WALK:  ;
      kmgd_pkg::ST_DONE:  out_load = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmgd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= kmgd_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_ms <= cfg_wdata;
    end
  end

  // Captured item and walk registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req     <= kmgd_pkg::req_t'(s_axis_tuser);
      row_idx <= s_axis_tdata[kmgd_pkg::IDX_W-1:0];
      bits    <= kmgd_pkg::COLS'(s_axis_tdata[kmgd_pkg::IDX_W +: kmgd_pkg::BITS_W]);
    end
    if (state == kmgd_pkg::ST_APPLY) begin
      wk   <= '0;
      acc  <= '0;
      drow <= '0;
    end else if (state == kmgd_pkg::ST_WALK) begin
      wk  <= wk + 1'b1;
      acc <= acc + kmgd_pkg::ACC_W'(walk_ones);
      if (row_ok && (wk == row_sel)) drow <= walk_val;
    end
  end

  // Matrix state, pending flag and timer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < kmgd_pkg::ROWS; r++) begin
        raw_rows[r]    <= '0;
        stable_rows[r] <= '0;
      end
      pending    <= 1'b0;
      elapsed_ms <= '0;
      commit     <= 1'b0;
    end else begin
      if (in_fire) commit <= 1'b0;
      if (state == kmgd_pkg::ST_APPLY) begin
        case (req)
          kmgd_pkg::REQ_SAMPLE: begin
            if (row_ok) begin
              if (raw_rd != bits) begin
                pending    <= 1'b1;
                elapsed_ms <= '0;
              end
              raw_rows[row_sel] <= bits;
            end
          end
          kmgd_pkg::REQ_TICK: begin
            if (elapsed_ms != kmgd_pkg::ELAPSED_MAX) elapsed_ms <= elapsed_ms + 1'b1;
          end
          kmgd_pkg::REQ_SCAN_END: begin
            if (commit_ok) begin
              commit  <= 1'b1;
              pending <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if ((state == kmgd_pkg::ST_WALK) && commit) stable_rows[wk] <= raw_rd;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= kmgd_pkg::OUT_DATA_W'({key_count, kmgd_pkg::OROW_W'(drow)});
      m_axis_tuser <= {commit, pending};
    end
  end

  // A result that reports a commit never shows the change still pending.
  a_commit_clears_pending: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("commit reported with change still pending");

  // A changed row sample restarts the timer and marks the change.
  a_change_restarts_timer: assert property (@(posedge clk) disable iff (rst)
    (state == kmgd_pkg::ST_APPLY) && (req == kmgd_pkg::REQ_SAMPLE) && row_ok && (raw_rd != bits)
    |=> pending && (elapsed_ms == '0))
    else $error("changed row sample did not restart debounce timer");

  // Only an end-of-scan item may copy the raw rows.
  a_commit_only_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == kmgd_pkg::ST_APPLY) && (req != kmgd_pkg::REQ_SCAN_END) |=> !commit)
    else $error("commit raised by an item other than end of scan");

  // The key count never exceeds the size of the matrix.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> 32'(m_axis_tdata[kmgd_pkg::OROW_W +: kmgd_pkg::KCNT_W])
                      <= 32'(kmgd_pkg::ROWS * kmgd_pkg::COLS))
    else $error("key count exceeds matrix size");

endmodule

FILE: src/kmgd_popcount.sv
// Shared bit counter: number of pressed keys in one matrix row.
module kmgd_popcount (
  input  logic [kmgd_pkg::COLS-1:0]   row,
  output logic [kmgd_pkg::ONES_W-1:0] ones
);

  always_comb begin
    ones = '0;
    for (int c = 0; c < kmgd_pkg::COLS; c++) begin
      ones = ones + kmgd_pkg::ONES_W'(row[c]);
    end
  end

endmodule

FILE: test/key_matrix_global_debounce_tb.sv
// Self-checking testbench for the keyboard matrix scanner with one shared debounce timer.
`timescale 1ns / 100ps

module testbench;

  localparam int SETTLE_CYCLES = kmgd_pkg::ROWS + 6;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [kmgd_pkg::OROW_W-1:0] row;
    logic [kmgd_pkg::KCNT_W-1:0] keys;
    logic pending;
    logic committed;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [kmgd_pkg::DEB_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_axis_tready;
  logic [kmgd_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [kmgd_pkg::REQ_W-1:0] s_tuser = '0;
  logic m_axis_tvalid;
  logic m_tready = 1'b0;
  logic [kmgd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [kmgd_pkg::OUT_USER_W-1:0] m_axis_tuser;

  key_matrix_global_debounce DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted state of the scanner.
  logic [kmgd_pkg::COLS-1:0] raw_matrix [kmgd_pkg::ROWS];
  logic [kmgd_pkg::COLS-1:0] stable_matrix [kmgd_pkg::ROWS];
  logic change_waiting;
  logic [kmgd_pkg::ELAPSED_W-1:0] ms_elapsed;
  logic [kmgd_pkg::DEB_W-1:0] debounce_setting;

  scan_result_t expected_results [$];
  int failures = 0;
  int items_sent = 0;

  // Sender and receiver pacing.
  bit sender_gaps_on = 1'b1;
  int burst_left = 0;
  bit rx_always_ready = 1'b0;
  int hold_requests = 0;
  int holds_served = 0;
  int long_hold_cycles = 0;
  int rx_hold_left = 0;
  int rx_phase_left = 0;
  int rx_duty = 0;

  function automatic scan_result_t predict_request(input kmgd_pkg::req_t kind,
                                                   input logic [kmgd_pkg::IDX_W-1:0] idx,
                                                   input logic [kmgd_pkg::BITS_W-1:0] bits);
    scan_result_t res;
    int total;
    bit row_ok;
    res = '0;
    total = 0;
    row_ok = int'(idx) < kmgd_pkg::ROWS;
    case (kind)
      kmgd_pkg::REQ_SAMPLE: begin
        if (row_ok) begin
          if (raw_matrix[idx] != bits[kmgd_pkg::COLS-1:0]) begin
            change_waiting = 1'b1;
            ms_elapsed = '0;
          end
          raw_matrix[idx] = bits[kmgd_pkg::COLS-1:0];
        end
      end
      kmgd_pkg::REQ_TICK: begin
        if (ms_elapsed != kmgd_pkg::ELAPSED_MAX) ms_elapsed = ms_elapsed + 1'b1;
      end
      kmgd_pkg::REQ_SCAN_END: begin
        if (change_waiting && ms_elapsed > kmgd_pkg::ELAPSED_W'(debounce_setting)) begin
          for (int i = 0; i < kmgd_pkg::ROWS; i++) stable_matrix[i] = raw_matrix[i];
          change_waiting = 1'b0;
          res.committed = 1'b1;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < kmgd_pkg::ROWS; i++) total += $countones(stable_matrix[i]);
    if (total > kmgd_pkg::KEY_MAX) total = kmgd_pkg::KEY_MAX;
    res.row = row_ok ? kmgd_pkg::OROW_W'(stable_matrix[idx]) : '0;
    res.keys = kmgd_pkg::KCNT_W'(total);
    res.pending = change_waiting;
    return res;
  endfunction

  task automatic report_failure(input string what, input scan_result_t want,
                                input scan_result_t got);
    failures++;
    if (failures <= REPORT_LIMIT)
      $display({"%0t: %s: expected row=%h keys=%0d pending=%b committed=%b, ",
                "got row=%h keys=%0d pending=%b committed=%b"},
               $realtime, what, want.row, want.keys, want.pending, want.committed,
               got.row, got.keys, got.pending, got.committed);
  endtask

  // Offers one item at a rising edge and returns at the edge where it is taken.
  task automatic send_item(input kmgd_pkg::req_t kind, input logic [kmgd_pkg::IDX_W-1:0] idx,
                           input logic [kmgd_pkg::BITS_W-1:0] bits);
    int gap;
    if (sender_gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {{(kmgd_pkg::IN_DATA_W - kmgd_pkg::BITS_W - kmgd_pkg::IDX_W){1'b0}}, bits, idx};
    s_tuser <= kind;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    expected_results.push_back(predict_request(kind, idx, bits));
    items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_debounce(input logic [kmgd_pkg::DEB_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    debounce_setting = value;
  endtask

  // Result checker: the transaction completes at the rising edge after the sample.
  always @(negedge clk) begin
    scan_result_t got;
    scan_result_t want;
    if (!rst && m_axis_tvalid && m_tready) begin
      got.row = m_axis_tdata[kmgd_pkg::OROW_W-1:0];
      got.keys = m_axis_tdata[kmgd_pkg::OROW_W +: kmgd_pkg::KCNT_W];
      got.pending = m_axis_tuser[0];
      got.committed = m_axis_tuser[1];
      if (expected_results.size() == 0) begin
        report_failure("unexpected result", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got.row !== want.row || got.keys !== want.keys ||
            got.pending !== want.pending || got.committed !== want.committed)
          report_failure("result mismatch", want, got);
      end
    end
  end

  // Receiver: phases of varying readiness, plus long hold-offs on request.
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      rx_hold_left = long_hold_cycles;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (rx_always_ready) begin
      m_tready <= 1'b1;
    end else begin
      if (rx_phase_left == 0) begin
        rx_duty = $urandom_range(0, 3);
        rx_phase_left = $urandom_range(16, 128);
      end else begin
        rx_phase_left--;
      end
      m_tready <= (rx_duty == 0) || ($urandom_range(0, 3) >= rx_duty);
    end
  end

  task automatic test_reset_state();
    send_item(kmgd_pkg::REQ_SCAN_END, 3'd0, '1);
    send_item(kmgd_pkg::REQ_TICK, 3'd7, '0);
    send_item(kmgd_pkg::REQ_NONE, 3'd3, '1);
    send_item(kmgd_pkg::REQ_SAMPLE, 3'd5, '0);
  endtask

  task automatic test_commit_sequence();
    send_item(kmgd_pkg::REQ_SAMPLE, 3'd0, '1);
    send_item(kmgd_pkg::REQ_SAMPLE, 3'd7, 18'h2AAAA);
    send_item(kmgd_pkg::REQ_SCAN_END, 3'd7, '0);
    for (int i = 0; i < 5; i++) send_item(kmgd_pkg::REQ_TICK, kmgd_pkg::IDX_W'(i), '0);
    // Elapsed equals the interval here, which is not yet enough.
    send_item(kmgd_pkg::REQ_SCAN_END, 3'd0, '0);
    send_item(kmgd_pkg::REQ_TICK, 3'd2, '0);
    send_item(kmgd_pkg::REQ_SCAN_END, 3'd0, '0);
    send_item(kmgd_pkg::REQ_SCAN_END, 3'd7, '0);
    send_item(kmgd_pkg::REQ_SAMPLE, 3'd0, '1);
    send_item(kmgd_pkg::REQ_NONE, 3'd7, 18'h15555);
  endtask

  task automatic test_interval_extremes();
    write_debounce(8'd0);
    send_item(kmgd_pkg::REQ_SAMPLE, 3'd3, 18'h15555);
    send_item(kmgd_pkg::REQ_SCAN_END, 3'd3, '0);
    send_item(kmgd_pkg::REQ_TICK, 3'd3, '0);
    send_item(kmgd_pkg::REQ_SCAN_END, 3'd3, '0);
  endtask

  // The longest interval: the timer has to pass 255 before a commit is allowed.
  task automatic test_longest_interval();
    int i;
    write_debounce(8'd255);
    sender_gaps_on = 1'b0;
    rx_always_ready = 1'b1;
    send_item(kmgd_pkg::REQ_SAMPLE, 3'd1, 18'h3C0F0);
    for (i = 0; i < 255; i++)
      send_item(kmgd_pkg::REQ_TICK, kmgd_pkg::IDX_W'($urandom_range(0, 7)),
                kmgd_pkg::BITS_W'($urandom));
    send_item(kmgd_pkg::REQ_SCAN_END, 3'd1, '0);
    send_item(kmgd_pkg::REQ_TICK, 3'd4, '0);
    send_item(kmgd_pkg::REQ_SCAN_END, 3'd1, '0);
    rx_always_ready = 1'b0;
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    write_debounce(8'd1);
    sender_gaps_on = 1'b0;
    long_hold_cycles = 300;
    hold_requests++;
    for (int r = 0; r < kmgd_pkg::ROWS; r++)
      send_item(kmgd_pkg::REQ_SAMPLE, kmgd_pkg::IDX_W'(r), kmgd_pkg::BITS_W'($urandom));
    for (int i = 0; i < 3; i++)
      send_item(kmgd_pkg::REQ_TICK, kmgd_pkg::IDX_W'($urandom_range(0, 7)), '0);
    send_item(kmgd_pkg::REQ_SCAN_END, kmgd_pkg::IDX_W'($urandom_range(0, 7)), '0);
    for (int r = 0; r < kmgd_pkg::ROWS; r++)
      send_item(kmgd_pkg::REQ_SAMPLE, kmgd_pkg::IDX_W'(r), raw_matrix[r]);
    send_item(kmgd_pkg::REQ_SCAN_END, kmgd_pkg::IDX_W'($urandom_range(0, 7)), '0);
    sender_gaps_on = 1'b1;
  endtask

  // Mostly whole scan passes with occasional row changes; the rest is noise
  // and passes that are cut short.
  task automatic test_random_scans();
    logic [kmgd_pkg::DEB_W-1:0] settings [3];
    logic [kmgd_pkg::BITS_W-1:0] bits;
    int target;
    int ticks;
    settings[0] = 8'd2;
    settings[1] = 8'd0;
    settings[2] = kmgd_pkg::DEB_W'($urandom_range(1, 6));
    foreach (settings[p]) begin
      write_debounce(settings[p]);
      target = items_sent + 35;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(kmgd_pkg::req_t'($urandom_range(0, 3)),
                    kmgd_pkg::IDX_W'($urandom_range(0, 7)), kmgd_pkg::BITS_W'($urandom));
        end else begin
          for (int r = 0; r < kmgd_pkg::ROWS; r++) begin
            bits = raw_matrix[r];
            if ($urandom_range(0, 15) == 0) bits = bits ^ kmgd_pkg::BITS_W'($urandom);
            send_item(kmgd_pkg::REQ_SAMPLE, kmgd_pkg::IDX_W'(r), bits);
            if ($urandom_range(0, 31) == 0) break;
          end
          ticks = $urandom_range(0, 3);
          repeat (ticks)
            send_item(kmgd_pkg::REQ_TICK, kmgd_pkg::IDX_W'($urandom_range(0, 7)),
                      kmgd_pkg::BITS_W'($urandom));
          if ($urandom_range(0, 7) != 0)
            send_item(kmgd_pkg::REQ_SCAN_END, kmgd_pkg::IDX_W'($urandom_range(0, 7)),
                      kmgd_pkg::BITS_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < kmgd_pkg::ROWS; i++) begin
      raw_matrix[i] = '0;
      stable_matrix[i] = '0;
    end
    change_waiting = 1'b0;
    ms_elapsed = '0;
    debounce_setting = kmgd_pkg::DEBOUNCE_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_commit_sequence();
    test_interval_extremes();
    test_longest_interval();
    test_backpressure();
    test_random_scans();
    wait_idle();
    failures += expected_results.size();
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
